/* rtl/rsrs_pkg.sv */
package rsrs_pkg;

    localparam int BISECTION_STEPS = 16;

    localparam logic [23:0] FULL_SCALE = 24'hFFFFFF;

    localparam logic [1:0] CFG_INV_MASS_RATIO = 2'd0;
    localparam logic [1:0] CFG_SURFACE_POT    = 2'd1;
    localparam logic [1:0] CFG_RADIUS_LOW     = 2'd2;
    localparam logic [1:0] CFG_RADIUS_HIGH    = 2'd3;

    localparam logic [23:0] RST_INV_MASS_RATIO = 24'd65536;
    localparam logic [23:0] RST_SURFACE_POT    = 24'd245760;
    localparam logic [15:0] RST_RADIUS_LOW     = 16'd23330;
    localparam logic [15:0] RST_RADIUS_HIGH    = 16'd32768;

    localparam int SQRT_STAGES = 6;
    localparam int SQRT_PER    = 3;
    localparam int RCP_STAGES  = 6;
    localparam int RCP_PER     = 4;

    localparam logic [17:0] RCP_SAT_LIMIT = 18'd256;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] nu;
        logic [15:0]        lo;
        logic [15:0]        hi;
    } bis_item_t;

    typedef struct packed {
        logic [23:0] inv_mass;
        logic [23:0] surface;
    } cell_cfg_t;

endpackage

/* rtl/rsrs_isqrt.sv */
module rsrs_isqrt #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [35:0]   radicand,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [17:0]   root,
    output logic [SW-1:0] out_side
);

    localparam int N = rsrs_pkg::SQRT_STAGES;

    typedef struct packed {
        logic [19:0] rem;
        logic [17:0] root;
        logic [35:0] bits;
    } sqrt_stage_t;

    function automatic sqrt_stage_t sqrt_steps(input sqrt_stage_t cur);
        sqrt_stage_t acc;
        logic [21:0] wide;
        logic [21:0] trial;
        acc = cur;
        for (int j = 0; j < rsrs_pkg::SQRT_PER; j++)
        begin
            wide  = {acc.rem, acc.bits[35:34]};
            trial = {2'b00, acc.root, 2'b01};
            acc.bits = {acc.bits[33:0], 2'b00};
            if (wide >= trial)
            begin
                acc.rem  = 20'(wide - trial);
                acc.root = {acc.root[16:0], 1'b1};
            end
            else
            begin
                acc.rem  = wide[19:0];
                acc.root = {acc.root[16:0], 1'b0};
            end
        end
        return acc;
    endfunction

    sqrt_stage_t   stage_in   [N+1];
    sqrt_stage_t   stage_next [N];
    sqrt_stage_t   stage_reg  [N];
    logic          valid_in   [N+1];
    logic          valid_reg  [N];
    logic [SW-1:0] side_in    [N+1];
    logic [SW-1:0] side_reg   [N];

    assign stage_in[0] = '{rem: '0, root: '0, bits: radicand};
    assign valid_in[0] = in_valid;
    assign side_in[0]  = in_side;

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        assign stage_in[g+1]  = stage_reg[g];
        assign valid_in[g+1]  = valid_reg[g];
        assign side_in[g+1]   = side_reg[g];
        assign stage_next[g]  = sqrt_steps(stage_in[g]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < N; g++)
            begin
                valid_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int g = 0; g < N; g++)
            begin
                valid_reg[g] <= valid_in[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < N; g++)
            begin
                stage_reg[g] <= stage_next[g];
                side_reg[g]  <= side_in[g];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = stage_reg[N-1].root;
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/rsrs_recip.sv */
module rsrs_recip #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [17:0]   div_a,
    input  logic [17:0]   div_b,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [23:0]   quot_a,
    output logic [23:0]   quot_b,
    output logic [SW-1:0] out_side
);

    localparam int N = rsrs_pkg::RCP_STAGES;

    typedef struct packed {
        logic [17:0] x_a;
        logic [17:0] x_b;
        logic [17:0] p_a;
        logic [17:0] p_b;
        logic [23:0] q_a;
        logic [23:0] q_b;
        logic        sat_a;
        logic        sat_b;
    } rcp_stage_t;

    function automatic rcp_stage_t rcp_steps(input rcp_stage_t cur);
        rcp_stage_t acc;
        logic [18:0] wide_a;
        logic [18:0] wide_b;
        acc = cur;
        for (int j = 0; j < rsrs_pkg::RCP_PER; j++)
        begin
            wide_a = {acc.p_a, 1'b0};
            wide_b = {acc.p_b, 1'b0};
            if (wide_a >= {1'b0, acc.x_a})
            begin
                acc.p_a = 18'(wide_a - {1'b0, acc.x_a});
                acc.q_a = {acc.q_a[22:0], 1'b1};
            end
            else
            begin
                acc.p_a = wide_a[17:0];
                acc.q_a = {acc.q_a[22:0], 1'b0};
            end
            if (wide_b >= {1'b0, acc.x_b})
            begin
                acc.p_b = 18'(wide_b - {1'b0, acc.x_b});
                acc.q_b = {acc.q_b[22:0], 1'b1};
            end
            else
            begin
                acc.p_b = wide_b[17:0];
                acc.q_b = {acc.q_b[22:0], 1'b0};
            end
        end
        return acc;
    endfunction

    rcp_stage_t    stage_in   [N+1];
    rcp_stage_t    stage_next [N];
    rcp_stage_t    stage_reg  [N];
    logic          valid_in   [N+1];
    logic          valid_reg  [N];
    logic [SW-1:0] side_in    [N+1];
    logic [SW-1:0] side_reg   [N];

    assign stage_in[0] = '{x_a: div_a, x_b: div_b,
                           p_a: rsrs_pkg::RCP_SAT_LIMIT, p_b: rsrs_pkg::RCP_SAT_LIMIT,
                           q_a: '0, q_b: '0,
                           sat_a: (div_a <= rsrs_pkg::RCP_SAT_LIMIT),
                           sat_b: (div_b <= rsrs_pkg::RCP_SAT_LIMIT)};
    assign valid_in[0] = in_valid;
    assign side_in[0]  = in_side;

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        assign stage_in[g+1] = stage_reg[g];
        assign valid_in[g+1] = valid_reg[g];
        assign side_in[g+1]  = side_reg[g];
        assign stage_next[g] = rcp_steps(stage_in[g]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < N; g++)
            begin
                valid_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int g = 0; g < N; g++)
            begin
                valid_reg[g] <= valid_in[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < N; g++)
            begin
                stage_reg[g] <= stage_next[g];
                side_reg[g]  <= side_in[g];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quot_a    = stage_reg[N-1].sat_a ? rsrs_pkg::FULL_SCALE : stage_reg[N-1].q_a;
    assign quot_b    = stage_reg[N-1].sat_b ? rsrs_pkg::FULL_SCALE : stage_reg[N-1].q_b;
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/rsrs_cell.sv */
module rsrs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  rsrs_pkg::cell_cfg_t cfg,
    input  logic                in_valid,
    input  rsrs_pkg::bis_item_t in_item,
    output logic                out_valid,
    output rsrs_pkg::bis_item_t out_item
);

    typedef struct packed {
        rsrs_pkg::bis_item_t item;
        logic [15:0]         mid;
        logic signed [16:0]  lr;
        logic [15:0]         b;
    } side_t;

    localparam int SW = $bits(side_t);
    localparam logic signed [34:0] TERM2_HI = 35'(rsrs_pkg::FULL_SCALE);
    localparam logic signed [34:0] TERM2_LO = -TERM2_HI;

    // Entry: midpoint and the three small products.
    logic [16:0]        mid_sum;
    logic [15:0]        mid_a;
    logic signed [32:0] lr_prod;
    logic [31:0]        rr_prod;
    logic signed [31:0] nn_prod;

    assign mid_sum = {1'b0, in_item.lo} + {1'b0, in_item.hi};
    assign mid_a   = mid_sum[16:1];
    assign lr_prod = in_item.l * $signed({1'b0, mid_a});
    assign rr_prod = mid_a * mid_a;
    assign nn_prod = in_item.nu * in_item.nu;

    logic                a_valid_reg;
    rsrs_pkg::bis_item_t a_item_reg;
    logic [15:0]         a_mid_reg;
    logic signed [31:0]  a_lr_reg;
    logic [31:0]         a_rr_reg;
    logic [30:0]         a_nn_reg;

    // Radicand of the companion distance and the r^2 (1 - nu^2) product.
    logic [35:0] d_full;
    logic [35:0] d_clamp;
    logic [30:0] one_minus;
    logic [46:0] b_prod;

    assign d_full    = 36'h1_0000_0000 - {{2{a_lr_reg[31]}}, a_lr_reg, 2'b00}
                       + {4'b0000, a_rr_reg};
    assign d_clamp   = d_full[35] ? 36'd0 : d_full;
    assign one_minus = 31'h4000_0000 - a_nn_reg;
    assign b_prod    = a_rr_reg[31:16] * one_minus;

    logic                b_valid_reg;
    rsrs_pkg::bis_item_t b_item_reg;
    logic [15:0]         b_mid_reg;
    logic signed [16:0]  b_lr_reg;
    logic [46:0]         b_prod_reg;
    logic [35:0]         b_d_reg;

    side_t       sqrt_side_in;
    side_t       sqrt_side_out;
    logic        sqrt_valid;
    logic [17:0] sqrt_root;

    assign sqrt_side_in = '{item: b_item_reg, mid: b_mid_reg, lr: b_lr_reg,
                            b: b_prod_reg[45:30]};

    rsrs_isqrt #(.SW(SW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (b_valid_reg),
        .radicand (b_d_reg),
        .in_side  (sqrt_side_in),
        .out_valid(sqrt_valid),
        .root     (sqrt_root),
        .out_side (sqrt_side_out)
    );

    side_t       rcp_side;
    logic        rcp_valid;
    logic [23:0] term1;
    logic [23:0] inv_dist;

    rsrs_recip #(.SW(SW)) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sqrt_valid),
        .div_a    ({2'b00, sqrt_side_out.mid}),
        .div_b    (sqrt_root),
        .in_side  (sqrt_side_out),
        .out_valid(rcp_valid),
        .quot_a   (term1),
        .quot_b   (inv_dist),
        .out_side (rcp_side)
    );

    logic signed [25:0] diff;
    logic signed [50:0] m2;
    logic [24:0]        q_plus;
    logic [40:0]        m3;

    assign diff   = $signed({2'b00, inv_dist}) - 26'(rcp_side.lr);
    assign m2     = $signed({1'b0, cfg.inv_mass}) * diff;
    assign q_plus = {1'b0, cfg.inv_mass} + 25'h0_10000;
    assign m3     = q_plus * rcp_side.b;

    logic                p1_valid_reg;
    rsrs_pkg::bis_item_t p1_item_reg;
    logic [15:0]         p1_mid_reg;
    logic [23:0]         p1_t1_reg;
    logic signed [50:0]  p1_m2_reg;
    logic [40:0]         p1_m3_reg;

    logic signed [34:0] t2_wide;
    logic signed [24:0] term2;

    assign t2_wide = $signed(p1_m2_reg[50:16]);
    assign term2   = (t2_wide > TERM2_HI) ? 25'(TERM2_HI) :
                     (t2_wide < TERM2_LO) ? 25'(TERM2_LO) : 25'(t2_wide);

    logic                p2_valid_reg;
    rsrs_pkg::bis_item_t p2_item_reg;
    logic [15:0]         p2_mid_reg;
    logic [23:0]         p2_t1_reg;
    logic signed [24:0]  p2_t2_reg;
    logic [23:0]         p2_t3_reg;

    logic signed [26:0]  pot_sum;
    logic [23:0]         pot;
    logic                above;
    rsrs_pkg::bis_item_t item_next;

    assign pot_sum = $signed({3'b000, p2_t1_reg}) + 27'(p2_t2_reg)
                     + $signed({3'b000, p2_t3_reg});
    assign pot     = pot_sum[26] ? 24'd0 :
                     ((pot_sum[25:24] != 2'b00) ? rsrs_pkg::FULL_SCALE : pot_sum[23:0]);
    assign above   = pot > cfg.surface;

    always_comb
    begin
        item_next = p2_item_reg;
        if (above)
        begin
            item_next.lo = p2_mid_reg;
        end
        else
        begin
            item_next.hi = p2_mid_reg;
        end
    end

    logic                out_valid_reg;
    rsrs_pkg::bis_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            p1_valid_reg  <= rcp_valid;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg   <= in_item;
            a_mid_reg    <= mid_a;
            a_lr_reg     <= lr_prod[31:0];
            a_rr_reg     <= rr_prod;
            a_nn_reg     <= nn_prod[30:0];
            b_item_reg   <= a_item_reg;
            b_mid_reg    <= a_mid_reg;
            b_lr_reg     <= a_lr_reg[31:15];
            b_prod_reg   <= b_prod;
            b_d_reg      <= d_clamp;
            p1_item_reg  <= rcp_side.item;
            p1_mid_reg   <= rcp_side.mid;
            p1_t1_reg    <= term1;
            p1_m2_reg    <= m2;
            p1_m3_reg    <= m3;
            p2_item_reg  <= p1_item_reg;
            p2_mid_reg   <= p1_mid_reg;
            p2_t1_reg    <= p1_t1_reg;
            p2_t2_reg    <= term2;
            p2_t3_reg    <= p1_m3_reg[40:17];
            out_item_reg <= item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/roche_surface_radius_solver_top.sv */
// Channel   Handshake               Beat contents
// input     in_valid / in_ready     cos_x_axis, cos_z_axis (signed Q1.15)
// output    out_valid / out_ready   surface_radius (Q0.16 of separation)
// config    cfg_we                  cfg_index, cfg_data
//
// One direction is accepted every cycle while the chain is not stalled (in_ready high).
// Each bisection cell is 17 stages: products, radicand, a 6-stage square root,
// a 6-stage dual reciprocal and three stages of potential sum and compare.
// Reset clears all valid flags and loads the register defaults.
// The whole chain stalls only when its last stage and the output register both hold a beat
// and the output beat is not taken in that cycle.
module roche_surface_radius_solver_top #(
    parameter int BISECTION_STEPS = rsrs_pkg::BISECTION_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] cos_x_axis,
    input  logic [15:0] cos_z_axis,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] surface_radius,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [23:0] inv_mass_reg;
    logic [23:0] surface_reg;
    logic [15:0] radius_low_reg;
    logic [15:0] radius_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg    <= rsrs_pkg::RST_INV_MASS_RATIO;
            surface_reg     <= rsrs_pkg::RST_SURFACE_POT;
            radius_low_reg  <= rsrs_pkg::RST_RADIUS_LOW;
            radius_high_reg <= rsrs_pkg::RST_RADIUS_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsrs_pkg::CFG_INV_MASS_RATIO: inv_mass_reg    <= cfg_data;
                rsrs_pkg::CFG_SURFACE_POT:    surface_reg     <= cfg_data;
                rsrs_pkg::CFG_RADIUS_LOW:     radius_low_reg  <= cfg_data[15:0];
                rsrs_pkg::CFG_RADIUS_HIGH:    radius_high_reg <= cfg_data[15:0];
                default:                      ;
            endcase
        end
    end

    rsrs_pkg::cell_cfg_t cfg;
    assign cfg = '{inv_mass: inv_mass_reg, surface: surface_reg};

    rsrs_pkg::bis_item_t chain_item  [BISECTION_STEPS+1];
    logic                chain_valid [BISECTION_STEPS+1];
    logic                en;

    assign chain_item[0]  = '{l: cos_x_axis, nu: cos_z_axis,
                              lo: radius_low_reg, hi: radius_high_reg};
    assign chain_valid[0] = in_valid;

    for (genvar g = 0; g < BISECTION_STEPS; g++)
    begin : g_cell
        rsrs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cfg      (cfg),
            .in_valid (chain_valid[g]),
            .in_item  (chain_item[g]),
            .out_valid(chain_valid[g+1]),
            .out_item (chain_item[g+1])
        );
    end

    logic        out_valid_reg;
    logic [15:0] radius_reg;
    logic        load;
    logic [16:0] final_sum;

    assign load      = out_ready || !out_valid_reg;
    assign en        = !chain_valid[BISECTION_STEPS] || load;
    assign in_ready  = en;
    assign final_sum = {1'b0, chain_item[BISECTION_STEPS].lo}
                       + {1'b0, chain_item[BISECTION_STEPS].hi};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= chain_valid[BISECTION_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            radius_reg <= final_sum[16:1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign surface_radius = radius_reg;

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[BISECTION_STEPS] && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while the chain is blocked");

    a_output_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(chain_valid[BISECTION_STEPS]))
        else $error("output beat without a finished item");

    a_finished_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (load && chain_valid[BISECTION_STEPS]) |=> out_valid_reg)
        else $error("finished item lost at the output register");

endmodule
